// File: rtl/tsdw_pkg.sv
package tsdw_pkg;

   localparam int TICK_W = 64;
   localparam int SECS_W = 32;
   localparam int REM_W = 29;
   localparam int CSR_W = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_FENCE_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRACE = 1'd1;

   localparam longint unsigned TEN_YEARS_SECONDS = 64'd315360000;
   localparam int GRACE_RESET_SECONDS = 30;

   typedef enum logic [1:0] {
      ACT_TICK = 2'd0,
      ACT_ARM = 2'd1,
      ACT_READ = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      MODE_CRASH = 2'd0,
      MODE_RESTART = 2'd1,
      MODE_HALT = 2'd2,
      MODE_NETFILTER = 2'd3
   } fence_mode_type;

   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_PANIC = 2'd1,
      EV_RESTART = 2'd2,
      EV_HALT = 2'd3
   } fence_event_type;

   typedef enum logic [1:0] {
      STG_NONE = 2'd0,
      STG_FIRST = 2'd1,
      STG_ESCALATED = 2'd2
   } fence_stage_type;

   typedef struct packed {
      logic is_read;
      logic infinite;
      logic expired;
      logic status;
      fence_event_type fence_ev;
   } tag_type;

endpackage

// File: rtl/two_stage_deadline_watchdog.sv
// Throughput: one transaction per cycle unless rsp_ready stalls the output; the tick
// counter and deadline registers are updated in a single stage, and the read path
// divides by a reciprocal multiply spread over four stages behind it.
// Reset (synchronous): tick counter zero, deadline disarmed (all ones), not fenced,
// fence mode crash, grace 30 seconds, pipeline empty.
module two_stage_deadline_watchdog #(
   parameter int TICKS_PER_SECOND = 1000
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_action,
   input  logic [tsdw_pkg::SECS_W-1:0]           req_timer_seconds,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_fence_event,
   output logic                                  rsp_expired,
   output logic [tsdw_pkg::REM_W-1:0]            rsp_remaining_seconds,
   output logic                                  rsp_remaining_infinite,
   output logic                                  rsp_status,
   input  logic                                  csr_write_enable,
   input  logic [tsdw_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tsdw_pkg::CSR_W-1:0]            csr_write_data
);

   localparam int NSTG = 8;
   localparam int TW = tsdw_pkg::TICK_W;
   localparam int RW = tsdw_pkg::REM_W;
   localparam int TPS_W = $clog2(TICKS_PER_SECOND + 1);
   localparam int SPAN_W = tsdw_pkg::SECS_W + TPS_W;
   localparam logic [TW-1:0] MAX_SPAN =
      TW'(tsdw_pkg::TEN_YEARS_SECONDS) * TW'(TICKS_PER_SECOND);
   localparam int LEFT_W = $clog2(MAX_SPAN + 1);
   localparam int GRACE_W = $clog2(255 * TICKS_PER_SECOND + 1);
   localparam int RECIP_W = LEFT_W + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((65'(1) << LEFT_W) / TICKS_PER_SECOND);
   localparam int LO_W = (LEFT_W + 1) / 2;
   localparam int HI_W = LEFT_W - LO_W;
   localparam int MHI_W = RECIP_W - LO_W;
   localparam int PLL_W = LO_W + LO_W;
   localparam int PLH_W = LO_W + MHI_W;
   localparam int PHL_W = HI_W + LO_W;
   localparam int PHH_W = HI_W + MHI_W;
   localparam int P_W = LEFT_W + RECIP_W;

   // pipeline control
   logic [NSTG-1:0] valid_ff, valid_in, load;

   // configuration and watchdog state
   tsdw_pkg::fence_mode_type mode_ff, mode_in;
   logic [GRACE_W-1:0] grace_ticks_ff, grace_ticks_in;
   logic [TW-1:0] tick_ff, tick_in;
   logic [TW-1:0] deadline_ff, deadline_in;
   tsdw_pkg::fence_stage_type stage_ff, stage_in;

   // stage payloads
   tsdw_pkg::action_type act0_ff;
   logic [tsdw_pkg::SECS_W-1:0] secs0_ff;
   tsdw_pkg::action_type act1_ff;
   logic [LEFT_W-1:0] span1_ff;
   logic zero1_ff, reject1_ff;
   logic [SPAN_W-1:0] span_full;
   logic [TW-1:0] tick2_ff, dl2_ff;
   tsdw_pkg::tag_type tag2_ff, tag2_in, tag3_ff, tag4_ff, tag5_ff, tag6_ff;
   tsdw_pkg::tag_type tag3_in, tag4_in;
   logic [TW-1:0] left3_ff;
   logic [LEFT_W-1:0] l4_ff, l5_ff, l6_ff;
   logic [PLL_W-1:0] pp_ll_ff;
   logic [PLH_W-1:0] pp_lh_ff;
   logic [PHL_W-1:0] pp_hl_ff;
   logic [PHH_W-1:0] pp_hh_ff;
   logic [P_W-1:0] prod_sum;
   logic [RW-1:0] qest5_ff, qest6_ff, quot;
   logic [LEFT_W-1:0] prod6_ff, rem7;

   // output register
   tsdw_pkg::tag_type tag7_ff;
   logic [RW-1:0] remaining7_ff;

   tsdw_pkg::fence_event_type first_ev;
   logic [TW-1:0] past_dl;
   logic fire;

   // a stage takes new data when it is empty or its contents move on
   always_comb begin
      load[NSTG-1] = !valid_ff[NSTG-1] || rsp_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in = ({valid_ff[NSTG-2:0], req_valid} & load) | (valid_ff & ~load);
   end

   assign req_ready = load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      grace_ticks_in = grace_ticks_ff;
      if (csr_write_enable) begin
         case (csr_index)
            tsdw_pkg::CSR_FENCE_MODE: begin
               mode_in = tsdw_pkg::fence_mode_type'(csr_write_data[1:0]);
            end
            tsdw_pkg::CSR_GRACE: begin
               grace_ticks_in = GRACE_W'(csr_write_data) * GRACE_W'(TICKS_PER_SECOND);
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (mode_ff)
         tsdw_pkg::MODE_CRASH: first_ev = tsdw_pkg::EV_PANIC;
         tsdw_pkg::MODE_RESTART: first_ev = tsdw_pkg::EV_RESTART;
         default: first_ev = tsdw_pkg::EV_HALT;
      endcase
   end

   // state update: the check tests the incremented count, done here on the old one
   always_comb begin
      tick_in = tick_ff;
      deadline_in = deadline_ff;
      stage_in = stage_ff;
      tag2_in = '0;
      tag2_in.fence_ev = tsdw_pkg::EV_NONE;
      tag2_in.is_read = (act1_ff == tsdw_pkg::ACT_READ);
      past_dl = tick_ff - deadline_ff;
      fire = (tick_ff >= deadline_ff) && (tick_ff != '1) &&
             (mode_ff != tsdw_pkg::MODE_NETFILTER);
      if (valid_ff[1] && load[2]) begin
         case (act1_ff)
            tsdw_pkg::ACT_TICK: begin
               tick_in = tick_ff + TW'(1);
               if (fire) begin
                  if (stage_ff == tsdw_pkg::STG_NONE) begin
                     stage_in = tsdw_pkg::STG_FIRST;
                     tag2_in.fence_ev = first_ev;
                  end else if (stage_ff == tsdw_pkg::STG_FIRST &&
                               past_dl >= TW'(grace_ticks_ff)) begin
                     stage_in = tsdw_pkg::STG_ESCALATED;
                     tag2_in.fence_ev = tsdw_pkg::EV_PANIC;
                  end
               end
            end
            tsdw_pkg::ACT_ARM: begin
               if (zero1_ff) begin
                  deadline_in = '1;
               end else if (reject1_ff) begin
                  tag2_in.status = 1'b1;
               end else begin
                  deadline_in = tick_ff + TW'(span1_ff);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= tsdw_pkg::MODE_CRASH;
         grace_ticks_ff <= GRACE_W'(tsdw_pkg::GRACE_RESET_SECONDS * TICKS_PER_SECOND);
         tick_ff <= '0;
         deadline_ff <= '1;
         stage_ff <= tsdw_pkg::STG_NONE;
      end else begin
         mode_ff <= mode_in;
         grace_ticks_ff <= grace_ticks_in;
         tick_ff <= tick_in;
         deadline_ff <= deadline_in;
         stage_ff <= stage_in;
      end
   end

   assign span_full = SPAN_W'(secs0_ff) * SPAN_W'(TICKS_PER_SECOND);

   always_comb begin
      tag3_in = tag2_ff;
      tag3_in.expired = (tick2_ff > dl2_ff);
      tag4_in = tag3_ff;
      tag4_in.infinite = tag3_ff.is_read && (left3_ff > MAX_SPAN);
   end

   always_comb begin
      prod_sum = (P_W'(pp_hh_ff) << (2 * LO_W)) + (P_W'(pp_lh_ff) << LO_W) +
                 (P_W'(pp_hl_ff) << LO_W) + P_W'(pp_ll_ff);
      rem7 = l6_ff - prod6_ff;
      quot = qest6_ff + RW'(rem7 >= LEFT_W'(TICKS_PER_SECOND));
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         act0_ff <= tsdw_pkg::action_type'(req_action);
         secs0_ff <= req_timer_seconds;
      end
      if (load[1]) begin
         act1_ff <= act0_ff;
         span1_ff <= span_full[LEFT_W-1:0];
         zero1_ff <= (secs0_ff == '0);
         reject1_ff <= (secs0_ff > tsdw_pkg::SECS_W'(tsdw_pkg::TEN_YEARS_SECONDS));
      end
      if (load[2]) begin
         tick2_ff <= tick_in;
         dl2_ff <= deadline_in;
         tag2_ff <= tag2_in;
      end
      if (load[3]) begin
         tag3_ff <= tag3_in;
         left3_ff <= dl2_ff - tick2_ff;
      end
      if (load[4]) begin
         tag4_ff <= tag4_in;
         l4_ff <= left3_ff[LEFT_W-1:0];
         pp_ll_ff <= PLL_W'(left3_ff[LO_W-1:0]) * PLL_W'(RECIP[LO_W-1:0]);
         pp_lh_ff <= PLH_W'(left3_ff[LO_W-1:0]) * PLH_W'(RECIP[RECIP_W-1:LO_W]);
         pp_hl_ff <= PHL_W'(left3_ff[LEFT_W-1:LO_W]) * PHL_W'(RECIP[LO_W-1:0]);
         pp_hh_ff <= PHH_W'(left3_ff[LEFT_W-1:LO_W]) * PHH_W'(RECIP[RECIP_W-1:LO_W]);
      end
      if (load[5]) begin
         tag5_ff <= tag4_ff;
         l5_ff <= l4_ff;
         qest5_ff <= RW'(prod_sum >> LEFT_W);
      end
      if (load[6]) begin
         tag6_ff <= tag5_ff;
         l6_ff <= l5_ff;
         qest6_ff <= qest5_ff;
         prod6_ff <= LEFT_W'(qest5_ff) * LEFT_W'(TICKS_PER_SECOND);
      end
      if (load[7]) begin
         tag7_ff <= tag6_ff;
         remaining7_ff <= (tag6_ff.is_read && !tag6_ff.infinite) ? quot : '0;
      end
   end

   assign rsp_valid = valid_ff[NSTG-1];
   assign rsp_fence_event = tag7_ff.fence_ev;
   assign rsp_expired = tag7_ff.expired;
   assign rsp_remaining_seconds = remaining7_ff;
   assign rsp_remaining_infinite = tag7_ff.infinite;
   assign rsp_status = tag7_ff.status;

   a_stage_sticky: assert property (@(posedge clock) disable iff (reset)
      stage_ff == tsdw_pkg::STG_ESCALATED |=> stage_ff == tsdw_pkg::STG_ESCALATED)
      else $error("fence stage left escalated");

   a_escalate_from_first: assert property (@(posedge clock) disable iff (reset)
      (stage_ff == tsdw_pkg::STG_ESCALATED && $past(stage_ff) != tsdw_pkg::STG_ESCALATED)
      |-> $past(stage_ff) == tsdw_pkg::STG_FIRST)
      else $error("escalated fence without a first fence");

   a_infinite_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_remaining_infinite |-> rsp_remaining_seconds == '0)
      else $error("remaining count with infinite flag");

   a_remaining_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_remaining_seconds <= RW'(tsdw_pkg::TEN_YEARS_SECONDS))
      else $error("remaining seconds beyond ten years");

endmodule

// File: sim/tb_two_stage_deadline_watchdog.sv
module tb_two_stage_deadline_watchdog;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TICKS_PER_SECOND = 1000;
   localparam int LATENCY_CYCLES = 7;
   localparam int LIMIT_CYCLES = 200000;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [tsdw_pkg::TICK_W-1:0] DISARMED = '1;
   localparam logic [tsdw_pkg::TICK_W-1:0] MAX_SPAN_TICKS =
      tsdw_pkg::TEN_YEARS_SECONDS * TICKS_PER_SECOND;
   localparam logic [tsdw_pkg::SECS_W-1:0] MAX_ARM_SECONDS =
      tsdw_pkg::SECS_W'(tsdw_pkg::TEN_YEARS_SECONDS);

   typedef struct packed {
      tsdw_pkg::fence_event_type fence_event;
      logic expired;
      logic [tsdw_pkg::REM_W-1:0] remaining;
      logic infinite;
      logic status;
   } watchdog_result_type;

   class watchdog_checker_type;
      logic [tsdw_pkg::TICK_W-1:0] ticks;
      logic [tsdw_pkg::TICK_W-1:0] deadline_ticks;
      tsdw_pkg::fence_stage_type stage;
      tsdw_pkg::fence_mode_type mode;
      logic [tsdw_pkg::CSR_W-1:0] grace;
      watchdog_result_type pending_results[$];
      int mismatches;

      function new();
         ticks = '0;
         deadline_ticks = DISARMED;
         stage = tsdw_pkg::STG_NONE;
         mode = tsdw_pkg::MODE_CRASH;
         grace = tsdw_pkg::CSR_W'(tsdw_pkg::GRACE_RESET_SECONDS);
         mismatches = 0;
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      function void apply_register(logic [tsdw_pkg::CSR_IDX_W-1:0] idx,
                                   logic [tsdw_pkg::CSR_W-1:0] data);
         case (idx)
            tsdw_pkg::CSR_FENCE_MODE: mode = tsdw_pkg::fence_mode_type'(data[1:0]);
            tsdw_pkg::CSR_GRACE: grace = data;
            default: ;
         endcase
      endfunction

      function void apply_request(logic [1:0] act, logic [tsdw_pkg::SECS_W-1:0] secs);
         watchdog_result_type r;
         logic [tsdw_pkg::TICK_W-1:0] span;
         logic [tsdw_pkg::TICK_W-1:0] left;
         r = '0;
         case (act)
            tsdw_pkg::ACT_TICK: begin
               ticks = ticks + 1;
               if (ticks > deadline_ticks && mode != tsdw_pkg::MODE_NETFILTER) begin
                  if (stage == tsdw_pkg::STG_NONE) begin
                     stage = tsdw_pkg::STG_FIRST;
                     case (mode)
                        tsdw_pkg::MODE_CRASH: r.fence_event = tsdw_pkg::EV_PANIC;
                        tsdw_pkg::MODE_RESTART: r.fence_event = tsdw_pkg::EV_RESTART;
                        default: r.fence_event = tsdw_pkg::EV_HALT;
                     endcase
                  end else if (stage == tsdw_pkg::STG_FIRST &&
                               ticks - deadline_ticks >
                               tsdw_pkg::TICK_W'(grace) *
                               tsdw_pkg::TICK_W'(TICKS_PER_SECOND)) begin
                     stage = tsdw_pkg::STG_ESCALATED;
                     r.fence_event = tsdw_pkg::EV_PANIC;
                  end
               end
            end
            tsdw_pkg::ACT_ARM: begin
               span = tsdw_pkg::TICK_W'(secs) * tsdw_pkg::TICK_W'(TICKS_PER_SECOND);
               if (secs == '0)
                  deadline_ticks = DISARMED;
               else if (span > MAX_SPAN_TICKS)
                  r.status = 1'b1;
               else
                  deadline_ticks = ticks + span;
            end
            tsdw_pkg::ACT_READ: begin
               // past the deadline the difference wraps and reads as infinite
               left = deadline_ticks - ticks;
               if (left > MAX_SPAN_TICKS)
                  r.infinite = 1'b1;
               else
                  r.remaining = tsdw_pkg::REM_W'(left / TICKS_PER_SECOND);
            end
            default: ;
         endcase
         r.expired = ticks > deadline_ticks;
         pending_results.push_back(r);
      endfunction

      function void check_response(watchdog_result_type got);
         watchdog_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result ev=%0d exp=%0b rem=%0d inf=%0b st=%0b",
                        got.fence_event, got.expired, got.remaining, got.infinite,
                        got.status);
         end else begin
            want = pending_results.pop_front();
            if (got.fence_event !== want.fence_event || got.expired !== want.expired ||
                got.remaining !== want.remaining || got.infinite !== want.infinite ||
                got.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at %0t: expected ev=%0d exp=%0b rem=%0d inf=%0b st=%0b",
                           $realtime, want.fence_event, want.expired, want.remaining,
                           want.infinite, want.status);
                  $display("   got ev=%0d exp=%0b rem=%0d inf=%0b st=%0b",
                           got.fence_event, got.expired, got.remaining, got.infinite,
                           got.status);
               end
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_action;
   logic [tsdw_pkg::SECS_W-1:0] req_timer_seconds;
   logic rsp_valid;
   logic rsp_ready;
   logic [1:0] rsp_fence_event;
   logic rsp_expired;
   logic [tsdw_pkg::REM_W-1:0] rsp_remaining_seconds;
   logic rsp_remaining_infinite;
   logic rsp_status;
   logic csr_write_enable;
   logic [tsdw_pkg::CSR_IDX_W-1:0] csr_index;
   logic [tsdw_pkg::CSR_W-1:0] csr_write_data;

   watchdog_checker_type tracker = new();
   watchdog_result_type observed;
   int accepted_items = 0;
   int cycle_count = 0;

   two_stage_deadline_watchdog #(
      .TICKS_PER_SECOND(TICKS_PER_SECOND)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_timer_seconds(req_timer_seconds),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_fence_event(rsp_fence_event),
      .rsp_expired(rsp_expired),
      .rsp_remaining_seconds(rsp_remaining_seconds),
      .rsp_remaining_infinite(rsp_remaining_infinite),
      .rsp_status(rsp_status),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #4 clock = ~clock;

   function automatic logic steady_window();
      return accepted_items >= 400 && accepted_items < 650;
   endfunction

   function automatic logic [tsdw_pkg::SECS_W-1:0] random_seconds();
      case ($urandom_range(0, 9))
         0: return '0;
         1, 2, 3: return tsdw_pkg::SECS_W'($urandom_range(1, 3));
         4, 5: return tsdw_pkg::SECS_W'($urandom_range(1, MAX_ARM_SECONDS));
         6: return MAX_ARM_SECONDS;
         7: return MAX_ARM_SECONDS + 1;
         default: return tsdw_pkg::SECS_W'($urandom);
      endcase
   endfunction

   // Monitor: one process notes writes, accepted transactions and results in a fixed order.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAIL two_stage_deadline_watchdog");
         $finish;
      end else if (!reset) begin
         if (csr_write_enable)
            tracker.apply_register(csr_index, csr_write_data);
         if (req_valid && req_ready) begin
            tracker.apply_request(req_action, req_timer_seconds);
            accepted_items++;
         end
         if (rsp_valid && rsp_ready) begin
            observed.fence_event = tsdw_pkg::fence_event_type'(rsp_fence_event);
            observed.expired = rsp_expired;
            observed.remaining = rsp_remaining_seconds;
            observed.infinite = rsp_remaining_infinite;
            observed.status = rsp_status;
            tracker.check_response(observed);
         end
      end
   end

   initial begin
      int held;
      logic held_once;
      held_once = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_once && accepted_items >= 250) begin
            held_once = 1'b1;
            // hold off long enough for the pipeline and the input to back up
            for (held = 0; held < 80; held++) begin
               rsp_ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_ready <= steady_window() || $urandom_range(0, 99) >= 36;
      end
   end

   task automatic send_item(input logic [1:0] act,
                            input logic [tsdw_pkg::SECS_W-1:0] secs);
      @(negedge clock);
      while (!steady_window() && $urandom_range(0, 99) < 36) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_timer_seconds <= secs;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic program_register(input logic [tsdw_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [tsdw_pkg::CSR_W-1:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0)
         @(negedge clock);
      csr_index <= idx;
      csr_write_data <= data;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mix that keeps the deadline where it is: ticks, reads, unused codes, rejected arms.
   task automatic send_quiet_item(output logic ticked);
      int pick;
      pick = $urandom_range(0, 99);
      ticked = 1'b0;
      if (pick < 94) begin
         send_item(tsdw_pkg::ACT_TICK, $urandom);
         ticked = 1'b1;
      end else if (pick < 97)
         send_item(tsdw_pkg::ACT_READ, $urandom);
      else if (pick < 98)
         send_item(ACT_UNUSED, $urandom);
      else
         send_item(tsdw_pkg::ACT_ARM, $urandom_range(MAX_ARM_SECONDS + 1, 32'hFFFF_FFFF));
   endtask

   task automatic send_random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         send_item(tsdw_pkg::ACT_TICK, $urandom);
      else if (pick < 70)
         send_item(tsdw_pkg::ACT_READ, $urandom);
      else if (pick < 95)
         send_item(tsdw_pkg::ACT_ARM, random_seconds());
      else
         send_item(ACT_UNUSED, $urandom);
   endtask

   initial begin
      int ticks_since_arm;
      logic ticked;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = tsdw_pkg::ACT_TICK;
      req_timer_seconds = '0;
      csr_write_enable = 1'b0;
      csr_index = tsdw_pkg::CSR_FENCE_MODE;
      csr_write_data = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: disarmed read, span limits, truncation, unused code, disarm
      send_item(tsdw_pkg::ACT_READ, '0);
      send_item(tsdw_pkg::ACT_TICK, '0);
      send_item(tsdw_pkg::ACT_ARM, 32'hFFFF_FFFF);
      send_item(tsdw_pkg::ACT_ARM, MAX_ARM_SECONDS + 1);
      send_item(tsdw_pkg::ACT_ARM, MAX_ARM_SECONDS);
      send_item(tsdw_pkg::ACT_READ, '0);
      send_item(tsdw_pkg::ACT_TICK, 32'hFFFF_FFFF);
      send_item(tsdw_pkg::ACT_READ, 32'hFFFF_FFFF);
      send_item(ACT_UNUSED, 32'hFFFF_FFFF);
      send_item(tsdw_pkg::ACT_ARM, 1);
      send_item(tsdw_pkg::ACT_READ, '0);
      send_item(tsdw_pkg::ACT_TICK, '0);
      send_item(tsdw_pkg::ACT_READ, '0);
      send_item(ACT_UNUSED, '0);
      send_item(tsdw_pkg::ACT_ARM, '0);
      send_item(tsdw_pkg::ACT_READ, '0);
      send_item(tsdw_pkg::ACT_TICK, '0);

      // netfilter: run past the deadline without fencing
      program_register(tsdw_pkg::CSR_FENCE_MODE, tsdw_pkg::CSR_W'(tsdw_pkg::MODE_NETFILTER));
      program_register(tsdw_pkg::CSR_GRACE, tsdw_pkg::CSR_W'($urandom_range(1, 254)));
      send_item(tsdw_pkg::ACT_ARM, 1);
      ticks_since_arm = 0;
      while (ticks_since_arm < TICKS_PER_SECOND + 20) begin
         send_quiet_item(ticked);
         if (ticked)
            ticks_since_arm++;
      end

      // still expired: first fence on the next tick, long grace holds off escalation
      program_register(tsdw_pkg::CSR_FENCE_MODE,
         tsdw_pkg::CSR_W'($urandom_range(tsdw_pkg::MODE_CRASH, tsdw_pkg::MODE_HALT)));
      program_register(tsdw_pkg::CSR_GRACE, 8'hFF);
      send_item(tsdw_pkg::ACT_TICK, $urandom);
      repeat (30) send_quiet_item(ticked);

      // zero grace: escalate on the next tick, then free-running traffic
      program_register(tsdw_pkg::CSR_FENCE_MODE, tsdw_pkg::CSR_W'(tsdw_pkg::MODE_CRASH));
      program_register(tsdw_pkg::CSR_GRACE, 8'h00);
      send_item(tsdw_pkg::ACT_TICK, $urandom);
      repeat (40) send_random_item();

      program_register(tsdw_pkg::CSR_FENCE_MODE,
         tsdw_pkg::CSR_W'($urandom_range(tsdw_pkg::MODE_CRASH, tsdw_pkg::MODE_NETFILTER)));
      program_register(tsdw_pkg::CSR_GRACE, tsdw_pkg::CSR_W'($urandom_range(0, 255)));
      repeat (40) send_random_item();

      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0)
         @(negedge clock);
      repeat (LATENCY_CYCLES * 2) @(negedge clock);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0)
         $display("PASS two_stage_deadline_watchdog");
      else
         $display("FAIL two_stage_deadline_watchdog");
      $finish;
   end

endmodule

// File: files.f
rtl/tsdw_pkg.sv
rtl/two_stage_deadline_watchdog.sv
sim/tb_two_stage_deadline_watchdog.sv
